// ===== hdl/linear_forecast_exceedance_defines.svh =====
// Assertion macros shared by the RTL that asserts.
`ifndef LINEAR_FORECAST_EXCEEDANCE_DEFINES_SVH
`define LINEAR_FORECAST_EXCEEDANCE_DEFINES_SVH

// Same-cycle implication.
`define LFE_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define LFE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/lfe_pkg.sv =====
`default_nettype none

package lfe_pkg;

   localparam int FRAC_BITS = 8;
   localparam int PROB_BITS = 16;
   localparam int QB        = 30;

   // Q30 constants
   localparam logic [30:0] Q_ONE  = 31'd1 << QB;
   localparam logic [63:0] Q_HALF = 64'd1 << (QB - 1);
   localparam logic [27:0] K_A    = 28'd248723596;
   localparam logic [28:0] K_D    = 29'd428361012;

   // polynomial coefficients, highest order first
   localparam logic signed [32:0] POLY_COEF [5] = '{
      33'sd1428371292,
      -33'sd1955558716,
      33'sd1912847369,
      -33'sd382857446,
      33'sd342933307
   };

   localparam logic signed [29:0] BASE_OFS  = 30'(500 << FRAC_BITS);
   localparam logic [22:0]        SIGMA_RST = 23'd256;
   localparam logic [31:0]        TD_REM0   = 32'd1 << 28;

   localparam int                 P_SH     = QB - PROB_BITS;
   localparam logic [63:0]        P_RND    = 64'd1 << (P_SH - 1);
   localparam logic [PROB_BITS:0] PROB_LO  = (PROB_BITS + 1)'((1 << PROB_BITS) / 100);
   localparam logic [PROB_BITS:0] PROB_HI  = (PROB_BITS + 1)'(((1 << PROB_BITS) * 99) / 100);
   localparam logic [PROB_BITS-1:0] PROB_MID = PROB_BITS'(1 << (PROB_BITS - 1));

   // stage map
   localparam int ST_NUM    = 1;
   localparam int ST_SPLIT  = 2;
   localparam int ZD_FIRST  = 3;
   localparam int ZD_LAST   = 12;
   localparam int ST_ZQ     = 13;
   localparam int TD_INIT   = 14;
   localparam int H_FIRST   = 14;
   localparam int H_LAST    = 49;
   localparam int TD_FIRST  = 15;
   localparam int TD_LAST   = 30;
   localparam int PL_FIRST  = 31;
   localparam int PL_LAST   = 40;
   localparam int SQ_FIRST  = 50;
   localparam int SQ_LAST   = 54;
   localparam int ST_P1     = 55;
   localparam int ST_PP     = 56;
   localparam int ST_SEL    = 57;
   localparam int ST_OUT    = 58;
   localparam int NST       = 59;

   typedef enum logic [2:0] {
      REG_LEAD  = 3'd0,
      REG_SLOPE = 3'd1,
      REG_PRIOR = 3'd2,
      REG_SIGMA = 3'd3
   } csr_reg_type;

   typedef enum logic [1:0] {
      TRUST_NONE = 2'd0,
      TRUST_LOW  = 2'd1,
      TRUST_HIGH = 2'd2
   } trust_type;

   typedef struct packed {
      logic signed [23:0]    thr;
      logic signed [30:0]    num;
      logic                  neg;
      logic                  sat;
      logic [26:0]           zrem;
      logic [19:0]           zsh;
      logic [30:0]           s;
      logic [31:0]           den;
      logic [31:0]           trem;
      logic [31:0]           tsh;
      logic [30:0]           acc;
      logic [61:0]           hprod;
      logic [30:0]           hx;
      logic [62:0]           hmq;
      logic signed [32:0]    psum;
      logic signed [32:0]    poly;
      logic [30:0]           p1;
      logic signed [32:0]    pp;
      logic [30:0]           prob;
      logic [PROB_BITS-1:0]  prob_q;
   } pipe_type;

endpackage

`default_nettype wire

// ===== hdl/linear_forecast_exceedance.sv =====
// A word accepted on the input is registered through st_ff[0] to st_ff[ST_OUT], whose valid bit is rsp_valid.
// Throughput: one word per cycle; a stalled result stalls the whole pipeline.
// The pipeline has 59 stages: two-bit dividers, Horner and Q30 multiplier stages.
// Reset: synchronous, active high; clears the valid bits and loads register defaults
// (predictors zero, sigma one).
`default_nettype none

`include "linear_forecast_exceedance_defines.svh"

module linear_forecast_exceedance (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic signed [23:0]             req_cut_level,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [lfe_pkg::PROB_BITS-1:0]       rsp_prob_above,
   output logic [1:0]                          rsp_trust_code,
   output logic                                rsp_no_data,
   input  wire logic                           csr_we,
   input  wire logic [2:0]                     csr_index,
   input  wire logic [23:0]                    csr_wdata
);
   import lfe_pkg::*;

   // Configuration registers
   logic signed [23:0] lead_ff;
   logic signed [23:0] slope_ff;
   logic signed [23:0] prior_ff;
   logic [22:0]        sigma_ff;

   // Derived terms, reloaded every cycle; config must only move while idle, which the block does not enforce
   logic signed [29:0] cfgsum_ff, cfgsum_in;
   logic [26:0]        sig10_ff, sig10_in;
   logic [29:0]        sig80_ff, sig80_in;
   logic [25:0]        sig5_ff, sig5_in;
   logic [22:0]        sig_eff;

   // Pipeline
   pipe_type           st_ff [NST];
   pipe_type           st_in [NST];
   logic [NST-1:0]     vld_ff;
   logic               adv;
   logic               no_data;

   // Decode register writes; drop writes beyond the list.
   always_ff @(posedge clock) begin
      if (reset) begin
         lead_ff  <= '0;
         slope_ff <= '0;
         prior_ff <= '0;
         sigma_ff <= SIGMA_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_LEAD:  lead_ff  <= csr_wdata;
            REG_SLOPE: slope_ff <= csr_wdata;
            REG_PRIOR: prior_ff <= csr_wdata;
            REG_SIGMA: sigma_ff <= csr_wdata[22:0];
            default: ;
         endcase
      end
   end

   // Fixed part of the forecast numerator: -(500 << FRAC) - 6*lead + 20*slope - 2*prior.
   // A zero sigma counts as one LSB.
   always_comb begin
      sig_eff   = (sigma_ff == '0) ? 23'd1 : sigma_ff;
      cfgsum_in = 30'sd20 * 30'(slope_ff) - 30'sd6 * 30'(lead_ff)
                  - 30'sd2 * 30'(prior_ff) - BASE_OFS;
      sig10_in  = 27'(sig_eff) * 27'd10;
      sig80_in  = 30'(sig_eff) * 30'd80;
      sig5_in   = 26'(sig_eff) * 26'd5;
   end

   always_ff @(posedge clock) begin
      cfgsum_ff <= cfgsum_in;
      sig10_ff  <= sig10_in;
      sig80_ff  <= sig80_in;
      sig5_ff   <= sig5_in;
   end

   // The whole pipe advances when the output register is empty or being taken.
   assign adv       = !vld_ff[ST_OUT] || rsp_ready;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NST-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff <= st_in;
      end
   end

   // Capture the threshold word.
   always_comb begin
      st_in[0]     = '0;
      st_in[0].thr = req_cut_level;
   end

   for (genvar k = 1; k < NST; k++) begin : g_st
      // Horner step and sub-phase for this stage; the divisor counts 12 down to 1
      localparam int HJ = (k - H_FIRST) / 3;
      localparam int HS = (k - H_FIRST) % 3;
      localparam int HI = (HJ >= 0 && HJ < 12) ? 12 - HJ : 1;
      localparam logic [31:0] HM = 32'((64'd1 << 31) / HI);
      // polynomial step and sub-phase
      localparam int PN  = (k - PL_FIRST) / 2;
      localparam int PS  = (k - PL_FIRST) % 2;
      localparam int PNI = (PN >= 0 && PN < 5) ? PN : 0;

      always_comb begin : p_stage
         pipe_type           x;
         logic [29:0]        mag;
         logic [46:0]        dvd;
         logic [27:0]        zr2;
         logic [32:0]        tr2;
         logic [31:0]        q0;
         logic [31:0]        rr;
         logic [31:0]        term;
         logic [32:0]        pmag;
         logic [63:0]        wide;
         logic [32:0]        pc;
         logic [PROB_BITS:0] qw;

         x    = st_ff[k-1];
         mag  = '0;
         dvd  = '0;
         zr2  = '0;
         tr2  = '0;
         q0   = '0;
         rr   = '0;
         term = '0;
         pmag = '0;
         wide = '0;
         pc   = '0;
         qw   = '0;

         if (k == ST_NUM) begin
            x.num = 31'(x.thr) * 31'sd10 + 31'(cfgsum_ff);
         end

         // Sign, saturation test and divider setup for zq = |N|*2^16 / (10*sigma)
         if (k == ST_SPLIT) begin
            x.neg  = x.num[30];
            mag    = 30'(x.num[30] ? -x.num : x.num);
            x.sat  = mag > sig80_ff;
            dvd    = x.sat ? '0 : ({mag, 16'd0} + 47'(sig5_ff));
            x.zrem = dvd[46:20];
            x.zsh  = dvd[19:0];
         end

         if (k >= ZD_FIRST && k <= ZD_LAST) begin
            for (int b = 0; b < 2; b++) begin
               zr2   = {x.zrem, x.zsh[19]};
               x.zsh = {x.zsh[18:0], 1'b0};
               if (zr2 >= {1'b0, sig10_ff}) begin
                  x.zrem   = 27'(zr2 - {1'b0, sig10_ff});
                  x.zsh[0] = 1'b1;
               end else begin
                  x.zrem = zr2[26:0];
               end
            end
         end

         // zq ready: exponent argument and the divisor of t
         if (k == ST_ZQ) begin
            x.s    = 31'((40'(x.zsh) * 40'(x.zsh)) >> 8);
            x.den  = 32'(Q_ONE) + 32'((48'(K_A) * 48'(x.zsh)) >> 16);
            x.acc  = Q_ONE;
            x.poly = '0;
         end

         if (k == TD_INIT) begin
            x.trem = TD_REM0;
            x.tsh  = {1'b0, x.den[31:1]};
         end

         if (k >= TD_FIRST && k <= TD_LAST) begin
            for (int b = 0; b < 2; b++) begin
               tr2   = {x.trem, x.tsh[31]};
               x.tsh = {x.tsh[30:0], 1'b0};
               if (tr2 >= {1'b0, x.den}) begin
                  x.trem   = 32'(tr2 - {1'b0, x.den});
                  x.tsh[0] = 1'b1;
               end else begin
                  x.trem = tr2[31:0];
               end
            end
         end

         // Horner step: multiply, round and scale by reciprocal, correct
         if (k >= H_FIRST && k <= H_LAST) begin
            if (HS == 0) begin
               x.hprod = 62'(x.s) * 62'(x.acc);
            end else if (HS == 1) begin
               x.hx  = 31'((64'(x.hprod) + Q_HALF) >> QB);
               x.hmq = 63'(x.hx) * 63'(HM);
            end else begin
               q0    = 32'(x.hmq >> 31);
               rr    = 32'(x.hx) - 32'(q0 * 32'(HI));
               term  = (rr >= 32'(HI)) ? q0 + 32'd1 : q0;
               x.acc = (term > 32'(Q_ONE)) ? '0 : 31'(32'(Q_ONE) - term);
            end
         end

         if (k >= PL_FIRST && k <= PL_LAST) begin
            if (PS == 0) begin
               x.psum = POLY_COEF[PNI] + x.poly;
            end else begin
               pmag   = x.psum[32] ? 33'(-x.psum) : 33'(x.psum);
               wide   = (64'(x.tsh[30:0]) * 64'(pmag) + Q_HALF) >> QB;
               pc     = 33'(wide);
               x.poly = x.psum[32] ? -$signed(pc) : $signed(pc);
            end
         end

         if (k >= SQ_FIRST && k <= SQ_LAST) begin
            x.acc = 31'((64'(x.acc) * 64'(x.acc) + Q_HALF) >> QB);
         end

         if (k == ST_P1) begin
            x.p1 = 31'((64'(K_D) * 64'(x.acc) + Q_HALF) >> QB);
         end

         if (k == ST_PP) begin
            pmag = x.poly[32] ? 33'(-x.poly) : 33'(x.poly);
            wide = (64'(x.p1) * 64'(pmag) + Q_HALF) >> QB;
            pc   = 33'(wide);
            x.pp = x.poly[32] ? -$signed(pc) : $signed(pc);
         end

         // Clamp the tail mass to [0, 1] and pick the side.
         if (k == ST_SEL) begin
            if (x.pp[32]) begin
               pc = '0;
            end else if (x.pp > $signed(33'(Q_ONE))) begin
               pc = 33'(Q_ONE);
            end else begin
               pc = 33'(x.pp);
            end
            if (x.sat) begin
               x.prob = x.neg ? Q_ONE : '0;
            end else begin
               x.prob = x.neg ? 31'(33'(Q_ONE) - pc) : 31'(pc);
            end
         end

         if (k == ST_OUT) begin
            qw = (PROB_BITS + 1)'((64'(x.prob) + P_RND) >> P_SH);
            if (qw < PROB_LO) begin
               qw = PROB_LO;
            end
            if (qw > PROB_HI) begin
               qw = PROB_HI;
            end
            x.prob_q = qw[PROB_BITS-1:0];
         end

         st_in[k] = x;
      end
   end

   // No data overrides the probability; the flags follow the registers.
   assign no_data        = (lead_ff == '0) && (prior_ff == '0);
   assign rsp_valid      = vld_ff[ST_OUT];
   assign rsp_no_data    = no_data;
   assign rsp_prob_above = no_data ? PROB_MID : st_ff[ST_OUT].prob_q;
   assign rsp_trust_code = no_data ? TRUST_NONE :
                           ((lead_ff > 24'sd0) ? TRUST_HIGH : TRUST_LOW);

   `LFE_ASSERT_IMPL(a_zdiv_pre, clock, reset, vld_ff[ST_SPLIT] && !st_ff[ST_SPLIT].sat, st_ff[ST_SPLIT].zrem < sig10_ff, "zq divider remainder out of range")
   `LFE_ASSERT_NEXT(a_t_range, clock, reset, adv && vld_ff[TD_LAST-1], st_ff[TD_LAST].tsh <= 32'(Q_ONE), "t above one")
   `LFE_ASSERT_IMPL(a_trust, clock, reset, rsp_valid, rsp_no_data == (rsp_trust_code == TRUST_NONE), "trust code disagrees with no_data")
   `LFE_ASSERT_IMPL(a_prob_rng, clock, reset, rsp_valid && !rsp_no_data, (rsp_prob_above >= PROB_LO) && (rsp_prob_above <= PROB_HI), "probability outside clamp")

endmodule

`default_nettype wire

// ===== tb/sv/linear_forecast_exceedance_tb.sv =====
`timescale 1ns / 1ps

module linear_forecast_exceedance_tb;
   import lfe_pkg::*;

   localparam int WATCHDOG_LIMIT = 6000;
   localparam int DRAIN_CYCLES   = 80;
   localparam int HOLD_CYCLES    = 300;

   typedef struct {
      logic [15:0] prob;
      trust_type   trust;
      logic        no_data;
   } exceed_result_type;

   // Scoreboard: keeps its own copy of the registers and the queue of
   // probabilities still owed by the pipeline.
   class exceed_board_type;
      longint            lead, slope, prior;
      longint unsigned   sigma;
      exceed_result_type owed[$];
      int                errors;

      function new();
         lead = 0; slope = 0; prior = 0; sigma = 256; errors = 0;
      endfunction

      function void set_reg(int idx, logic [23:0] v);
         case (idx)
            REG_LEAD:  lead  = longint'($signed(v));
            REG_SLOPE: slope = longint'($signed(v));
            REG_PRIOR: prior = longint'($signed(v));
            REG_SIGMA: sigma = longint'(v[22:0]);
            default: ;
         endcase
      endfunction

      function longint q30_const(longint unsigned n, longint unsigned d);
         return longint'(((n << 30) + d / 2) / d);
      endfunction

      // Q30 product, rounded half away from zero
      function longint q30_mul(longint a, longint b);
         longint unsigned ua, ub, p;
         ua = (a < 0) ? longint'(-a) : a;
         ub = (b < 0) ? longint'(-b) : b;
         p = (ua * ub + (64'd1 << 29)) >> 30;
         return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
      endfunction

      // upper tail mass for |z| = zq / 2^16, Q30
      function longint tail_mass(longint unsigned zq);
         longint unsigned den, s, acc, term;
         longint t, poly, p;
         den = (64'd1 << 30) + ((longint'(q30_const(2316419, 10000000)) * zq) >> 16);
         t = longint'(((64'd1 << 60) + den / 2) / den);
         s = (zq * zq) >> 8;
         acc = 64'd1 << 30;
         for (int i = 12; i >= 1; i--) begin
            term = ((s * acc + (64'd1 << 29)) >> 30) / i;
            acc = (term > (64'd1 << 30)) ? 0 : (64'd1 << 30) - term;
         end
         repeat (5) acc = (acc * acc + (64'd1 << 29)) >> 30;
         poly = q30_mul(t, q30_const(1330274429, 1000000000));
         poly = q30_mul(t, -q30_const(1821255978, 1000000000) + poly);
         poly = q30_mul(t, q30_const(1781477937, 1000000000) + poly);
         poly = q30_mul(t, -q30_const(356563782, 1000000000) + poly);
         poly = q30_mul(t, q30_const(319381530, 1000000000) + poly);
         p = q30_mul(q30_mul(q30_const(64'd3989422804, 64'd10000000000), longint'(acc)),
                     poly);
         if (p < 0) p = 0;
         if (p > (64'sd1 << 30)) p = 64'sd1 << 30;
         return p;
      endfunction

      function void note_cut(logic [23:0] cut);
         exceed_result_type r;
         longint            num, prob;
         longint unsigned   mag, sig, zq, q;
         if (lead == 0 && prior == 0) begin
            r.prob = 16'h8000; r.trust = TRUST_NONE; r.no_data = 1'b1;
         end else begin
            num = 10 * longint'($signed(cut)) - (longint'(500) << 8)
                  - 6 * lead + 20 * slope - 2 * prior;
            mag = (num < 0) ? longint'(-num) : num;
            sig = (sigma == 0) ? 1 : sigma;
            if (mag > 80 * sig) begin
               prob = (num > 0) ? 0 : (64'sd1 << 30);
            end else begin
               zq = ((mag << 16) + 5 * sig) / (10 * sig);
               prob = tail_mass(zq);
               if (num < 0) prob = (64'sd1 << 30) - prob;
            end
            q = (longint'(prob) + (64'd1 << 13)) >> 14;
            if (q < 655) q = 655;
            if (q > 64880) q = 64880;
            r.prob = q[15:0];
            r.trust = (lead > 0) ? TRUST_HIGH : TRUST_LOW;
            r.no_data = 1'b0;
         end
         owed.insert(owed.size(), r);
      endfunction

      function void check_word(logic [15:0] prob, logic [1:0] trust, logic nd);
         exceed_result_type e;
         if (owed.size() == 0) begin
            $display("%0t: unexpected word prob=%0d trust=%0d no_data=%0b",
                     $realtime, prob, trust, nd);
            errors++;
            return;
         end
         e = owed.pop_front();
         if (prob !== e.prob) begin
            $display("%0t: prob_above expected %0d actual %0d", $realtime, e.prob, prob);
            errors++;
         end
         if (trust !== e.trust) begin
            $display("%0t: trust_code expected %0d actual %0d", $realtime, e.trust, trust);
            errors++;
         end
         if (nd !== e.no_data) begin
            $display("%0t: no_data expected %0b actual %0b", $realtime, e.no_data, nd);
            errors++;
         end
      endfunction
   endclass

   logic        clock, reset;
   logic        req_valid, req_ready;
   logic [23:0] req_cut_level;
   logic        rsp_valid, rsp_ready;
   logic [15:0] rsp_prob_above;
   logic [1:0]  rsp_trust_code;
   logic        rsp_no_data;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [23:0] csr_wdata;

   exceed_board_type board;
   logic        hold_request;
   int          idle_cycles;
   int          burst_left, gap_max;

   linear_forecast_exceedance DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_cut_level(req_cut_level),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_prob_above(rsp_prob_above),
      .rsp_trust_code(rsp_trust_code), .rsp_no_data(rsp_no_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // Check every word that leaves on the result channel.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_word(rsp_prob_above, rsp_trust_code, rsp_no_data);
   end

   // Watchdog: count edges with no traffic on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("linear_forecast_exceedance_tb NOT OK");
            $finish;
         end
      end
   end

   // Receiver: pick a stall pattern for a while, then switch; honor a hold request
   // by dropping ready for a long counted stretch.
   initial begin
      int mode, span;
      rsp_ready = 1'b0;
      forever begin
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end
         mode = $urandom_range(0, 3);
         span = $urandom_range(5, 60);
         repeat (span) begin
            @(negedge clock);
            if (hold_request) break;
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 1) == 1);
               2: rsp_ready <= ($urandom_range(0, 4) == 0);
               default: rsp_ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // Offer one word; gaps between bursts are inserted here. Starts and ends at a
   // falling edge.
   task automatic send_cut(input logic [23:0] cut);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_cut_level <= cut;
      do @(posedge clock); while (!req_ready);
      board.note_cut(cut);
      @(negedge clock);
   endtask

   // Drop valid and hold until the pipeline has drained.
   task automatic drain_pipe();
      req_valid <= 1'b0;
      burst_left = 0;
      while (board.owed.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // One write, then the enable is dropped again before the task returns.
   task automatic write_reg(input int idx, input logic [23:0] v);
      csr_we    <= 1'b1;
      csr_index <= idx[2:0];
      csr_wdata <= v;
      board.set_reg(idx, v);
      @(negedge clock);
      csr_we    <= 1'b0;
      @(negedge clock);
   endtask

   task automatic write_all(input logic [23:0] l, s, p, sg);
      drain_pipe();
      write_reg(REG_LEAD, l);
      write_reg(REG_SLOPE, s);
      write_reg(REG_PRIOR, p);
      write_reg(REG_SIGMA, sg);
   endtask

   // Threshold near the forecast, offset by up to ten sigma either way, clipped to 24 bits.
   function automatic logic [23:0] aimed_cut();
      longint f10, sig, t;
      f10 = 128000 + 6 * board.lead - 20 * board.slope + 2 * board.prior;
      sig = (board.sigma == 0) ? 1 : board.sigma;
      t = (f10 + (longint'($urandom_range(0, 2000)) - 1000) * sig / 10) / 10;
      if (t > 8388607) t = 8388607;
      if (t < -8388608) t = -8388608;
      return t[23:0];
   endfunction

   task automatic run_phase(input int n);
      repeat (n) begin
         if ($urandom_range(0, 9) < 7) send_cut(aimed_cut());
         else send_cut(24'($urandom()));
      end
   endtask

   function automatic logic [23:0] rand_pred();
      case ($urandom_range(0, 4))
         0: return 24'd0;
         1: return 24'($urandom());
         default: return 24'($signed($urandom_range(0, 65535)) - 32768);
      endcase
   endfunction

   initial begin
      logic [23:0] l, p;
      board = new();
      hold_request = 1'b0;
      idle_cycles = 0;
      burst_left = 0;
      gap_max = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_cut_level = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // No data after reset: any threshold gives one half.
      send_cut(24'h800000);
      send_cut(24'h7FFFFF);
      send_cut(24'h000000);

      // Positive lead, threshold at the forecast, and both far tails.
      write_all(24'd25600, 24'd0, 24'd0, 24'd256);
      send_cut(24'd28160);
      send_cut(24'd28161);
      send_cut(24'h7FFFFF);
      send_cut(24'h800000);
      send_cut(24'd28160 + 24'd200);

      // Negative lead, nonzero slope and prior, zero sigma acting as one LSB.
      write_all(24'hFFFF00, 24'd512, 24'd1000, 24'd0);
      send_cut(aimed_cut());
      send_cut(24'd12700);
      send_cut(24'd12699);

      // Register extremes and a write to an unused index, which must be ignored.
      write_all(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'hFFFFFF);
      write_reg(REG_SIGMA + 1 + $urandom_range(0, 3), 24'd1);
      send_cut(24'h7FFFFF);
      send_cut(24'h800000);
      send_cut(aimed_cut());
      write_all(24'h800000, 24'h7FFFFF, 24'h800000, 24'd1);
      send_cut(24'h7FFFFF);
      send_cut(24'h800000);
      send_cut(aimed_cut());
      write_all(24'd0, 24'd777, 24'd300, 24'd1);
      send_cut(aimed_cut());

      // Random phases: each with a fresh register setting and its own gap size.
      for (int ph = 0; ph < 30; ph++) begin
         l = rand_pred();
         p = rand_pred();
         if (ph % 9 == 4) begin
            l = 0; p = 0;
         end
         write_all(l, rand_pred(),  p,
                   ($urandom_range(0, 5) == 0) ? 24'($urandom()) : 24'($urandom_range(0, 4000)));
         gap_max = (ph % 3 == 0) ? 0 : $urandom_range(1, 12);
         // Stall the receiver long enough that the pipeline backs up to the input;
         // offer more words than the pipeline holds.
         if (ph == 7) begin
            gap_max = 0;
            hold_request = 1'b1;
            run_phase(100);
         end else begin
            run_phase(50);
         end
      end

      drain_pipe();
      if (board.errors == 0)
         $display("linear_forecast_exceedance_tb OK");
      else
         $display("linear_forecast_exceedance_tb NOT OK");
      $finish;
   end

endmodule
